// File: hw/rtl/pnru_pkg.sv
// ----------------------------------------------------------------------------
// pnru_pkg - shared types and constants of the pink noise row updater
// Field widths, configuration indexes and reset values, action codes,
// sequencer states, adder opcodes, store write strobes and the trailing-zero helper.
// ----------------------------------------------------------------------------
`default_nettype none

package pnru_pkg;

    // Field widths
    localparam int PIX_W      = 8;
    localparam int RSEL_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int IDX_W      = 16;
    localparam int SUM_W      = 20;
    localparam int ACTIVE_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LENGTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_PIXELS = 2'd1;

    // Reset values of the configuration registers
    localparam logic [IDX_W-1:0]    SEQ_LENGTH_RST    = 16'hFFFF;
    localparam logic [ACTIVE_W-1:0] ACTIVE_PIXELS_RST = 9'd256;

    // Action codes
    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_INDEX,
        S_ROW,
        S_SUB,
        S_ADD,
        S_WB
    } state_t;

    // Shared adder opcodes
    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // Write strobes into the state store
    typedef struct packed {
        logic tick;
        logic sum;
        logic row;
    } store_we_t;

    // Position of the lowest set bit, 16 when the word is zero
    function automatic logic [4:0] tz16(input logic [IDX_W-1:0] v);
        logic [4:0] r;
        r = 5'd16;
        for (int i = IDX_W - 1; i >= 0; i--)
        begin
            if (v[i])
            begin
                r = 5'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pnru_item_if.sv
// ----------------------------------------------------------------------------
// pnru_item_if - input item channel
// Valid/ready channel carrying one action on one pixel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnru_item_if;
    logic                                valid;
    logic                                ready;
    logic                                action;
    logic [pnru_pkg::PIX_W-1:0]          pixel;
    logic [pnru_pkg::RSEL_W-1:0]         row_select;
    logic signed [pnru_pkg::SAMPLE_W-1:0] gauss_sample;

    modport source (output valid, action, pixel, row_select, gauss_sample, input ready);
    modport sink   (input valid, action, pixel, row_select, gauss_sample, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pnru_result_if.sv
// ----------------------------------------------------------------------------
// pnru_result_if - result channel
// Valid/ready channel carrying the outcome of one action.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnru_result_if;
    logic                              valid;
    logic                              ready;
    logic [pnru_pkg::PIX_W-1:0]        pixel_out;
    logic signed [pnru_pkg::SUM_W-1:0] noise_sum;
    logic [pnru_pkg::RSEL_W-1:0]       row_used;
    logic                              wrapped;
    logic                              skipped;

    modport source (output valid, pixel_out, noise_sum, row_used, wrapped, skipped,
                    input ready);
    modport sink   (input valid, pixel_out, noise_sum, row_used, wrapped, skipped,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pnru_cfg_if.sv
// ----------------------------------------------------------------------------
// pnru_cfg_if - configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface pnru_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [pnru_pkg::CFG_IDX_W-1:0]   index;
    logic [pnru_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pnru_alu.sv
// ----------------------------------------------------------------------------
// pnru_alu - shared adder/subtractor
// One 20-bit add/subtract unit, reused for the index increment and both
// halves of the sum update.
// ----------------------------------------------------------------------------
`default_nettype none

module pnru_alu (
    input  pnru_pkg::alu_op_t            op,
    input  logic [pnru_pkg::SUM_W-1:0]   a,
    input  logic [pnru_pkg::SUM_W-1:0]   b,
    output logic [pnru_pkg::SUM_W-1:0]   y
);
    import pnru_pkg::*;

    // Result wraps modulo 2^20
    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

`default_nettype wire

// File: hw/rtl/pnru_store.sv
// ----------------------------------------------------------------------------
// pnru_store - per-pixel generator state
// Tick index, running sum and row values in single-port memories with
// registered reads, zeroed by a sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pnru_store #(
    parameter int AW = 8,
    parameter int RW = 4
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [AW-1:0]                 px_addr,
    input  logic [RW-1:0]                 row_addr,
    input  pnru_pkg::store_we_t           we,
    input  logic [pnru_pkg::IDX_W-1:0]    tick_wdata,
    input  logic [pnru_pkg::SUM_W-1:0]    sum_wdata,
    input  logic [pnru_pkg::SAMPLE_W-1:0] row_wdata,
    output logic [pnru_pkg::IDX_W-1:0]    tick_rdata,
    output logic [pnru_pkg::SUM_W-1:0]    sum_rdata,
    output logic [pnru_pkg::SAMPLE_W-1:0] row_rdata,
    output logic                          clr_busy
);
    import pnru_pkg::*;

    localparam int PX_DEPTH  = 2 ** AW;
    localparam int ROW_DEPTH = 2 ** (AW + RW);

    logic [IDX_W-1:0]    tick_mem [PX_DEPTH];
    logic [SUM_W-1:0]    sum_mem  [PX_DEPTH];
    logic [SAMPLE_W-1:0] row_mem  [ROW_DEPTH];

    logic                clr_busy_reg;
    logic [AW+RW-1:0]    clr_addr_reg;

    logic [IDX_W-1:0]    tick_rdata_reg;
    logic [SUM_W-1:0]    sum_rdata_reg;
    logic [SAMPLE_W-1:0] row_rdata_reg;

    logic [AW-1:0]       px_waddr;
    logic [AW+RW-1:0]    row_waddr;

    // Clearing sweep, one row entry per cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (&clr_addr_reg)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    // Write addresses: sweep while clearing, otherwise the item's pixel
    always_comb
    begin
        if (clr_busy_reg)
        begin
            px_waddr  = clr_addr_reg[AW+RW-1:RW];
            row_waddr = clr_addr_reg;
        end
        else
        begin
            px_waddr  = px_addr;
            row_waddr = {px_addr, row_addr};
        end
    end

    // Memory writes and registered reads (read returns the old value)
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg || we.tick)
        begin
            tick_mem[px_waddr] <= clr_busy_reg ? '0 : tick_wdata;
        end
        if (clr_busy_reg || we.sum)
        begin
            sum_mem[px_waddr] <= clr_busy_reg ? '0 : sum_wdata;
        end
        if (clr_busy_reg || we.row)
        begin
            row_mem[row_waddr] <= clr_busy_reg ? '0 : row_wdata;
        end
        tick_rdata_reg <= tick_mem[px_addr];
        sum_rdata_reg  <= sum_mem[px_addr];
        row_rdata_reg  <= row_mem[{px_addr, row_addr}];
    end

    assign tick_rdata = tick_rdata_reg;
    assign sum_rdata  = sum_rdata_reg;
    assign row_rdata  = row_rdata_reg;
    assign clr_busy   = clr_busy_reg;

endmodule

`default_nettype wire

// File: hw/rtl/pink_noise_row_updater.sv
// ----------------------------------------------------------------------------
// pink_noise_row_updater - per-pixel Voss-McCartney row updater
// Ticks or loads one pixel's generator, replacing at most one row and
// updating the running sum through a shared adder under a small sequencer.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                                             Done when
//  -------  ---  --------------------------------------------------  ------------
//  item     in   action, pixel, row_select, gauss_sample             valid & ready
//  result   out  pixel_out, noise_sum, row_used, wrapped, skipped    valid & ready
//  cfg      in   index, data (0 sequence_length, 1 active_pixels)    valid & ready
//
//  Each transaction steps through accept, index increment, row pick and
//  row read, sum minus old, plus new, write-back. The shared adder is used
//  three times and each memory read is registered.
//  After reset a sweep zeroes the store's 2^(AW+RW) row entries (4096 by
//  default); item.ready stays low meanwhile, cfg writes are always taken.
//  A pending result holds in its register; write-back waits for it to go.
// ----------------------------------------------------------------------------
`default_nettype none

module pink_noise_row_updater #(
    parameter int PIXELS = 256,
    parameter int ROWS   = 16
) (
    input  logic              clk,
    input  logic              rst_n,
    pnru_item_if.sink         item,
    pnru_result_if.source     result,
    pnru_cfg_if.sink          cfg
);
    import pnru_pkg::*;

    // Only the first 256 pixels can be addressed
    localparam int DEPTH = (PIXELS < 256) ? PIXELS : 256;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = $clog2(ROWS);

    state_t state_reg, state_next;

    // Configuration
    logic [IDX_W-1:0]    seq_len_reg;
    logic [ACTIVE_W-1:0] active_reg;

    // Latched item and working values
    logic                action_reg;
    logic [PIX_W-1:0]    px_reg;
    logic [RSEL_W-1:0]   rsel_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic                skip_reg;
    logic                in_range_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [RW-1:0]       row_reg;
    logic                wrap_reg;
    logic                do_row_reg;
    logic [SUM_W-1:0]    acc_reg;

    // Result register
    logic                out_valid_reg;
    logic [PIX_W-1:0]    out_px_reg;
    logic [SUM_W-1:0]    out_sum_reg;
    logic [RSEL_W-1:0]   out_row_reg;
    logic                out_wrap_reg;
    logic                out_skip_reg;

    // Store and adder hookup
    logic [AW-1:0]       px_addr;
    logic [RW-1:0]       row_addr;
    store_we_t           we;
    logic [IDX_W-1:0]    tick_rdata;
    logic [SUM_W-1:0]    sum_rdata;
    logic [SAMPLE_W-1:0] row_rdata;
    logic                clr_busy;
    alu_op_t             alu_op;
    logic [SUM_W-1:0]    alu_a;
    logic [SUM_W-1:0]    alu_b;
    logic [SUM_W-1:0]    alu_y;

    logic                accept;
    logic                out_free;
    logic                wb_fire;
    logic                in_skip;
    logic                in_range;
    logic [4:0]          tz;
    logic [RW-1:0]       row_tick;
    logic [RW+RSEL_W-1:0] rsel_ext;
    logic [RW+RSEL_W-1:0] row_used_ext;
    logic                wrap_now;
    logic                rsel_ok;
    logic [RW-1:0]       row_pick;

    assign accept   = item.valid && item.ready;
    assign out_free = !out_valid_reg || result.ready;
    assign wb_fire  = (state_reg == S_WB) && out_free;

    // Pixel range checks on the incoming item
    assign in_range = 32'(item.pixel) < DEPTH;
    assign in_skip  = !in_range || ({1'b0, item.pixel} >= active_reg);

    // Row choice for the item at hand
    assign tz       = tz16(idx_reg);
    assign row_tick = (int'(tz) > ROWS - 1) ? RW'(ROWS - 1) : tz[RW-1:0];
    assign rsel_ext = (RW + RSEL_W)'(rsel_reg);
    assign rsel_ok  = 32'(rsel_reg) < ROWS;
    assign wrap_now = (action_reg == ACT_TICK) && (idx_reg == seq_len_reg);
    assign row_pick = (action_reg == ACT_TICK) ? row_tick : rsel_ext[RW-1:0];
    assign row_used_ext = (RW + RSEL_W)'(row_reg);

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SEQ_LENGTH_RST;
            active_reg  <= ACTIVE_PIXELS_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SEQ_LENGTH:    seq_len_reg <= cfg.data[IDX_W-1:0];
                CFG_ACTIVE_PIXELS: active_reg  <= cfg.data[ACTIVE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_INDEX;
            S_INDEX: state_next = S_ROW;
            S_ROW:   state_next = S_SUB;
            S_SUB:   state_next = S_ADD;
            S_ADD:   state_next = S_WB;
            S_WB:    if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Sequencer outputs: adder operands, store addresses and strobes
    always_comb
    begin
        item.ready = 1'b0;
        alu_op     = ALU_ADD;
        alu_a      = '0;
        alu_b      = '0;
        we         = '0;
        px_addr    = px_reg[AW-1:0];
        row_addr   = row_reg;
        case (state_reg)
            S_IDLE:
            begin
                item.ready = !clr_busy;
                px_addr    = item.pixel[AW-1:0];
            end
            S_INDEX:
            begin
                alu_a = {{(SUM_W-IDX_W){1'b0}}, tick_rdata};
                alu_b = SUM_W'(1);
            end
            S_ROW:
            begin
                row_addr = row_pick;
            end
            S_SUB:
            begin
                alu_op = ALU_SUB;
                alu_a  = sum_rdata;
                alu_b  = {{(SUM_W-SAMPLE_W){row_rdata[SAMPLE_W-1]}}, row_rdata};
            end
            S_ADD:
            begin
                alu_a = acc_reg;
                alu_b = {{(SUM_W-SAMPLE_W){sample_reg[SAMPLE_W-1]}}, sample_reg};
            end
            S_WB:
            begin
                we.tick = wb_fire && !skip_reg && (action_reg == ACT_TICK);
                we.sum  = wb_fire && do_row_reg;
                we.row  = wb_fire && do_row_reg;
            end
            default: ;
        endcase
    end

    // Item datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg   <= item.action;
            px_reg       <= item.pixel;
            rsel_reg     <= item.row_select;
            sample_reg   <= item.gauss_sample;
            skip_reg     <= in_skip;
            in_range_reg <= in_range;
        end
        if (state_reg == S_INDEX)
        begin
            idx_reg <= alu_y[IDX_W-1:0];
        end
        if (state_reg == S_ROW)
        begin
            row_reg    <= row_pick;
            wrap_reg   <= !skip_reg && wrap_now;
            do_row_reg <= !skip_reg && ((action_reg == ACT_TICK) ? !wrap_now : rsel_ok);
        end
        if (state_reg == S_SUB || state_reg == S_ADD)
        begin
            acc_reg <= alu_y;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (wb_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wb_fire)
        begin
            out_px_reg   <= px_reg;
            out_sum_reg  <= do_row_reg ? acc_reg : (in_range_reg ? sum_rdata : '0);
            out_row_reg  <= do_row_reg ? row_used_ext[RSEL_W-1:0] : '0;
            out_wrap_reg <= wrap_reg;
            out_skip_reg <= skip_reg;
        end
    end

    assign result.valid     = out_valid_reg;
    assign result.pixel_out = out_px_reg;
    assign result.noise_sum = out_sum_reg;
    assign result.row_used  = out_row_reg;
    assign result.wrapped   = out_wrap_reg;
    assign result.skipped   = out_skip_reg;

    pnru_store #(
        .AW (AW),
        .RW (RW)
    ) u_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .px_addr    (px_addr),
        .row_addr   (row_addr),
        .we         (we),
        .tick_wdata (wrap_reg ? '0 : idx_reg),
        .sum_wdata  (acc_reg),
        .row_wdata  (sample_reg),
        .tick_rdata (tick_rdata),
        .sum_rdata  (sum_rdata),
        .row_rdata  (row_rdata),
        .clr_busy   (clr_busy)
    );

    pnru_alu u_alu (
        .op (alu_op),
        .a  (alu_a),
        .b  (alu_b),
        .y  (alu_y)
    );

    // An accepted transaction always starts the index step
    a_accept_to_index: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_INDEX))
        else $error("accepted transaction did not start the sequence");

    // Results appear only from write-back
    a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_WB))
        else $error("result loaded outside write-back");

    // Store untouched while the clearing sweep runs
    a_no_write_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy |-> !(we.tick || we.sum || we.row))
        else $error("store write during clearing sweep");

    // A result never reports both a wrap and a skip, nor a row with either
    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(out_wrap_reg && out_skip_reg)
                          && ((out_row_reg == '0) || (!out_wrap_reg && !out_skip_reg)))
        else $error("inconsistent result flags");

endmodule

`default_nettype wire

// File: tb/tb_pink_noise_row_updater.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pink_noise_row_updater - self-checking bench for the pink noise updater
// Drives load and tick actions through the item channel, predicts each
// result with a behavioral copy of the per-pixel index, row and sum stores,
// and compares every result transaction field by field. Covers the field
// extremes, inactive pixels, wraps, a length lowered below the index and
// randomized traffic under several register settings.
// ----------------------------------------------------------------------------

module tb_pink_noise_row_updater;

    import pnru_pkg::*;

    localparam int NUM_PIXELS   = 256;
    localparam int NUM_ROWS     = 16;
    localparam int CYCLE_LIMIT  = 5_000_000;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 26;
    localparam int RAND_PHASES  = 7;
    localparam int PHASE_ITEMS  = 200;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0]        pixel;
        logic signed [SUM_W-1:0] sum;
        logic [RSEL_W-1:0]       row;
        logic                    wrapped;
        logic                    skipped;
    } noise_result_t;

    logic clk = 1'b0;
    logic rst_n;

    pnru_item_if   item_ch ();
    pnru_result_if res_ch ();
    pnru_cfg_if    cfg_ch ();

    pink_noise_row_updater #(
        .PIXELS (NUM_PIXELS),
        .ROWS   (NUM_ROWS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (res_ch),
        .cfg    (cfg_ch)
    );

    // Generator state as seen by the predictor
    logic [IDX_W-1:0]    tick_idx [NUM_PIXELS];
    logic [SUM_W-1:0]    px_sum   [NUM_PIXELS];
    logic [SAMPLE_W-1:0] row_val  [NUM_PIXELS][NUM_ROWS];
    logic [IDX_W-1:0]    seq_len;
    logic [ACTIVE_W-1:0] active_cnt;

    noise_result_t predicted_results [$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  idle_on     = 1'b1;

    // Clock
    always
    begin
        #5 clk = ~clk;
    end

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached", $time);
            $display("tb_pink_noise_row_updater NOT OK");
            $finish;
        end
    end

    // Row picked by a tick: trailing zeros of the new index, capped at the top row
    function automatic logic [RSEL_W-1:0] tz_row(input logic [IDX_W-1:0] idx);
        logic [RSEL_W-1:0] n;
        n = RSEL_W'(NUM_ROWS - 1);
        for (int i = NUM_ROWS - 2; i >= 0; i--)
        begin
            if (idx[i])
            begin
                n = RSEL_W'(i);
            end
        end
        return n;
    endfunction

    // Swap one row value and move the sum by new minus old
    function automatic void replace_row(input logic [PIX_W-1:0] px,
                                        input logic [RSEL_W-1:0] r,
                                        input logic [SAMPLE_W-1:0] smp);
        logic [SUM_W-1:0] old_ext;
        logic [SUM_W-1:0] new_ext;
        old_ext = {{(SUM_W - SAMPLE_W){row_val[px][r][SAMPLE_W-1]}}, row_val[px][r]};
        new_ext = {{(SUM_W - SAMPLE_W){smp[SAMPLE_W-1]}}, smp};
        px_sum[px] = px_sum[px] + new_ext - old_ext;
        row_val[px][r] = smp;
    endfunction

    // Apply one action to the generator copy and return its result
    function automatic noise_result_t advance_pixel(input logic act,
                                                    input logic [PIX_W-1:0] px,
                                                    input logic [RSEL_W-1:0] rsel,
                                                    input logic [SAMPLE_W-1:0] smp);
        noise_result_t r;
        logic [IDX_W-1:0]  nidx;
        logic [RSEL_W-1:0] row;
        r = '0;
        r.pixel = px;
        if ({1'b0, px} >= active_cnt)
        begin
            r.skipped = 1'b1;
        end
        else if (act == ACT_LOAD)
        begin
            replace_row(px, rsel, smp);
            r.row = rsel;
        end
        else
        begin
            nidx = tick_idx[px] + 16'd1;
            if (nidx == seq_len)
            begin
                tick_idx[px] = '0;
                r.wrapped = 1'b1;
            end
            else
            begin
                tick_idx[px] = nidx;
                row = tz_row(nidx);
                replace_row(px, row, smp);
                r.row = row;
            end
        end
        r.sum = px_sum[px];
        return r;
    endfunction

    // Random sample, leaning on the extremes now and then
    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int pick;
        pick = $urandom_range(99);
        if (pick < 3)
            return 16'h7FFF;
        else if (pick < 6)
            return 16'h8000;
        else if (pick < 8)
            return 16'h0000;
        else if (pick < 10)
            return 16'hFFFF;
        return SAMPLE_W'($urandom);
    endfunction

    // One item transaction; valid stays high afterwards unless the next call idles
    task automatic send_item(input logic act, input logic [PIX_W-1:0] px,
                             input logic [RSEL_W-1:0] rsel,
                             input logic [SAMPLE_W-1:0] smp);
        logic taken;
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                item_ch.valid <= 1'b0;
                @(posedge clk);
            end
        end
        item_ch.valid        <= 1'b1;
        item_ch.action       <= act;
        item_ch.pixel        <= px;
        item_ch.row_select   <= rsel;
        item_ch.gauss_sample <= smp;
        do
        begin
            @(negedge clk);
            taken = item_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        predicted_results.push_back(advance_pixel(act, px, rsel, smp));
    endtask

    // Register write, only issued with the block idle
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        logic taken;
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
        begin
            @(negedge clk);
            taken = cfg_ch.ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_ch.valid <= 1'b0;
        case (idx)
            CFG_SEQ_LENGTH:    seq_len    = data;
            CFG_ACTIVE_PIXELS: active_cnt = data[ACTIVE_W-1:0];
            default:           ;
        endcase
        @(posedge clk);
    endtask

    // Stop sending and let every outstanding result come back
    task automatic wait_drain();
        item_ch.valid <= 1'b0;
        while (predicted_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Field extremes, inactive pixels, wraps and a lowered length
    task automatic test_directed();
        send_item(ACT_LOAD, 8'd0,   4'd0,  16'h7FFF);
        send_item(ACT_LOAD, 8'd0,   4'd15, 16'h8000);
        send_item(ACT_LOAD, 8'd255, 4'd15, 16'h7FFF);
        send_item(ACT_LOAD, 8'd255, 4'd0,  16'h8000);
        send_item(ACT_LOAD, 8'd0,   4'd0,  16'hFFFF);
        send_item(ACT_TICK, 8'd0,   4'd0,  16'd100);
        send_item(ACT_TICK, 8'd0,   4'd9,  16'h8000);
        send_item(ACT_TICK, 8'd0,   4'd15, 16'h7FFF);
        send_item(ACT_TICK, 8'd0,   4'd5,  16'h0000);
        send_item(ACT_TICK, 8'd255, 4'd15, 16'h0001);
        send_item(ACT_LOAD, 8'd128, 4'd7,  16'h5555);

        // no pixel active
        wait_drain();
        cfg_write(CFG_ACTIVE_PIXELS, 16'h0000);
        send_item(ACT_TICK, 8'd0,   4'd0,  16'h1234);
        send_item(ACT_LOAD, 8'd255, 4'd15, 16'hABCD);

        // active boundary at 128, upper data bits ignored
        wait_drain();
        cfg_write(CFG_ACTIVE_PIXELS, 16'hFE80);
        send_item(ACT_TICK, 8'd127, 4'd0,  16'h0F0F);
        send_item(ACT_LOAD, 8'd128, 4'd3,  16'h7777);
        send_item(ACT_TICK, 8'd128, 4'd0,  16'h7777);

        // length 1 wraps on every tick from zero
        wait_drain();
        cfg_write(CFG_ACTIVE_PIXELS, 16'h0100);
        cfg_write(CFG_SEQ_LENGTH, 16'd1);
        send_item(ACT_TICK, 8'd1, 4'd0, 16'h4000);
        send_item(ACT_TICK, 8'd1, 4'd0, 16'h4000);

        // length below pixel 0's index: it keeps counting
        wait_drain();
        cfg_write(CFG_SEQ_LENGTH, 16'd3);
        send_item(ACT_TICK, 8'd0, 4'd0, 16'h0042);
        send_item(ACT_TICK, 8'd2, 4'd0, 16'h0101);
        send_item(ACT_TICK, 8'd2, 4'd0, 16'hF0F0);
        send_item(ACT_TICK, 8'd2, 4'd0, 16'h3333);
        send_item(ACT_TICK, 8'd2, 4'd0, 16'hCCCC);
    endtask

    // Random traffic over several register settings
    task automatic test_random();
        logic [IDX_W-1:0]    len;
        logic [ACTIVE_W-1:0] act_n;
        logic [PIX_W-1:0]    px;
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            wait_drain();
            case (ph)
                0:       begin len = 16'hFFFF; act_n = 9'd256; end
                1:       begin len = 16'd1;    act_n = 9'd4;   end
                2:       begin len = IDX_W'($urandom_range(2, 20)); act_n = 9'd255; end
                3:       begin len = 16'd0;    act_n = ACTIVE_W'($urandom_range(0, 256)); end
                4:       begin len = IDX_W'($urandom_range(1, 65535)); act_n = 9'd200; end
                5:       begin len = 16'd8;    act_n = 9'd256; end
                default: begin len = IDX_W'($urandom_range(2, 40)); act_n = 9'd6; end
            endcase
            cfg_write(CFG_SEQ_LENGTH, len);
            cfg_write(CFG_ACTIVE_PIXELS, {7'($urandom), act_n});
            if (ph == 3)
                cfg_write(CFG_SPARE, CFG_DATA_W'($urandom));
            // one phase runs with neither side idling
            idle_on = (ph != 5);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                px = ($urandom_range(99) < 70) ? PIX_W'($urandom_range(7))
                                               : PIX_W'($urandom_range(255));
                send_item(($urandom_range(99) < 75) ? ACT_TICK : ACT_LOAD, px,
                          RSEL_W'($urandom), rand_sample());
            end
        end
        idle_on = 1'b1;
    endtask

    // Result side back-pressure
    always @(posedge clk)
    begin
        res_ch.ready <= rst_n && !(idle_on && ($urandom_range(99) < IDLE_PCT));
    end

    task automatic compare_field(input string name, input logic signed [31:0] want_v,
                                 input logic signed [31:0] got_v);
        if (want_v !== got_v)
        begin
            fail_count++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
        end
    endtask

    // Check each result transaction against the oldest prediction
    always @(negedge clk)
    begin : check_results
        noise_result_t want;
        if (rst_n === 1'b1 && res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
        begin
            if (predicted_results.size() == 0)
            begin
                fail_count++;
                $display("%0t: result with none expected, actual pixel %0d sum %0d",
                         $time, res_ch.pixel_out, res_ch.noise_sum);
            end
            else
            begin
                want = predicted_results.pop_front();
                compare_field("pixel_out", want.pixel,   res_ch.pixel_out);
                compare_field("noise_sum", want.sum,     res_ch.noise_sum);
                compare_field("row_used",  want.row,     res_ch.row_used);
                compare_field("wrapped",   want.wrapped, res_ch.wrapped);
                compare_field("skipped",   want.skipped, res_ch.skipped);
            end
        end
    end

    // Sequence of tests
    initial
    begin
        seq_len    = SEQ_LENGTH_RST;
        active_cnt = ACTIVE_PIXELS_RST;
        for (int p = 0; p < NUM_PIXELS; p++)
        begin
            tick_idx[p] = '0;
            px_sum[p]   = '0;
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                row_val[p][r] = '0;
            end
        end

        rst_n                <= 1'b0;
        item_ch.valid        <= 1'b0;
        item_ch.action       <= ACT_LOAD;
        item_ch.pixel        <= '0;
        item_ch.row_select   <= '0;
        item_ch.gauss_sample <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_SEQ_LENGTH;
        cfg_ch.data          <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_random();
        wait_drain();

        if (fail_count == 0)
            $display("tb_pink_noise_row_updater OK");
        else
            $display("tb_pink_noise_row_updater NOT OK");
        $finish;
    end

endmodule
